// ----- rtl/aacc_pkg.sv -----
// ----------------------------------------------------------------------------
// ADC audio conditioning chain: shared package
// Register indexes, sequencer codes, micro-op decode and reset constants for
// the iterative filter datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package aacc_pkg;

  // Fixed format constants.
  localparam int          LP_FRAC    = 16;
  localparam logic [11:0] RAIL_MAX   = 12'd4095;
  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [31:0] SEED_RESET = 32'hDEADBEEF;

  // Register values after reset.
  localparam logic signed [23:0] HP_B0_RESET       = 24'sd1002984;
  localparam logic signed [23:0] HP_B1_RESET       = -24'sd2005957;
  localparam logic signed [23:0] HP_B2_RESET       = 24'sd1002984;
  localparam logic signed [23:0] HP_A1_RESET       = -24'sd2003986;
  localparam logic signed [23:0] HP_A2_RESET       = 24'sd958965;
  localparam logic [20:0]        LP_ALPHA_RESET    = 21'd986291;
  localparam logic [10:0]        CLIP_MARGIN_RESET = 11'd4;

  typedef enum logic [2:0] {
    REG_HP_B0       = 3'd0,
    REG_HP_B1       = 3'd1,
    REG_HP_B2       = 3'd2,
    REG_HP_A1       = 3'd3,
    REG_HP_A2       = 3'd4,
    REG_LP_ALPHA    = 3'd5,
    REG_CLIP_MARGIN = 3'd6,
    REG_DITHER_SEED = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  // One micro-op is one product followed by one accumulate.
  typedef enum logic [2:0] {
    OP_Y,
    OP_D1_PRE,
    OP_D1,
    OP_D2_PRE,
    OP_D2,
    OP_LP_PRE,
    OP_LP
  } op_t;

  typedef enum logic [2:0] {
    C_B0,
    C_B1,
    C_B2,
    C_A1,
    C_A2,
    C_ALPHA,
    C_BETA
  } coef_sel_t;

  typedef enum logic [1:0] {
    D_X,
    D_Y,
    D_U,
    D_LP
  } data_sel_t;

  typedef enum logic [1:0] {
    B_ZERO,
    B_D1,
    B_D2
  } base_sel_t;

  typedef enum logic [2:0] {
    W_NONE,
    W_Y,
    W_D1,
    W_D2,
    W_LP
  } dest_t;

  typedef struct packed {
    coef_sel_t coef;
    data_sel_t data;
    logic      shift;  // take the product down by the coefficient fraction
    logic      sub;    // subtract the term instead of adding it
    logic      start;  // open a new sum from the base value
    base_sel_t base;
    dest_t     dest;
  } op_ctrl_t;

  function automatic op_ctrl_t op_ctrl(op_t op);
    op_ctrl_t c;
    c = '{C_B0, D_X, 1'b0, 1'b0, 1'b1, B_ZERO, W_NONE};
    case (op)
      OP_Y:      c = '{C_B0,    D_X,  1'b0, 1'b0, 1'b1, B_D1,   W_Y};
      OP_D1_PRE: c = '{C_B1,    D_X,  1'b0, 1'b0, 1'b1, B_D2,   W_NONE};
      OP_D1:     c = '{C_A1,    D_Y,  1'b1, 1'b1, 1'b0, B_ZERO, W_D1};
      OP_D2_PRE: c = '{C_B2,    D_X,  1'b0, 1'b0, 1'b1, B_ZERO, W_NONE};
      OP_D2:     c = '{C_A2,    D_Y,  1'b1, 1'b1, 1'b0, B_ZERO, W_D2};
      OP_LP_PRE: c = '{C_ALPHA, D_U,  1'b1, 1'b0, 1'b1, B_ZERO, W_NONE};
      OP_LP:     c = '{C_BETA,  D_LP, 1'b1, 1'b0, 1'b0, B_ZERO, W_LP};
      default:   c = '{C_B0,    D_X,  1'b0, 1'b0, 1'b1, B_ZERO, W_NONE};
    endcase
    return c;
  endfunction

  function automatic op_t op_succ(op_t op);
    op_t n;
    n = OP_Y;
    case (op)
      OP_Y:      n = OP_D1_PRE;
      OP_D1_PRE: n = OP_D1;
      OP_D1:     n = OP_D2_PRE;
      OP_D2_PRE: n = OP_D2;
      OP_D2:     n = OP_LP_PRE;
      OP_LP_PRE: n = OP_LP;
      default:   n = OP_Y;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/adc_audio_conditioning_chain_unit.sv -----
// ----------------------------------------------------------------------------
// ADC audio conditioning chain
// Raw ADC statistics, biquad high-pass, one-pole low-pass, triangular dither
// and int16 saturation, computed on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A sample item is taken when the block is idle, and the block takes no new
// item until the result of the last one is loaded into the output register.
// A restart item goes straight to the done state. All products are formed
// on the single coefficient-by-17-bit multiplier: each of the seven products
// of one sample uses the centered sample directly or works over the 16-bit
// slices of a 48-bit filter value, and each product is followed by an
// accumulate step. A finished result waits in the output register while the
// next item is accepted. Configuration writes take effect at once and are
// meant for idle periods only.
`default_nettype none

module adc_audio_conditioning_chain_unit #(
  parameter int BUF_SAMPLES    = 1024,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [11:0]        raw_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pcm_out,
  output logic               buffer_select,
  output logic [9:0]         write_position,
  output logic               buffer_full,
  output logic [11:0]        min_raw,
  output logic [11:0]        max_raw,
  output logic [31:0]        clip_total,
  output logic [31:0]        sample_total
);

  localparam int CW     = (COEF_FRAC_BITS + 2 > 24) ? COEF_FRAC_BITS + 2 : 24;
  localparam int PW     = CW + 48;
  localparam int SW     = CW + 50 - COEF_FRAC_BITS;
  localparam int FILL_W = $clog2(BUF_SAMPLES);
  localparam int POS_W  = (FILL_W > 10) ? FILL_W : 10;

  localparam logic [CW-1:0]     ONE_Q     = CW'(1 << COEF_FRAC_BITS);
  localparam logic [FILL_W-1:0] LAST_FILL = FILL_W'(BUF_SAMPLES - 1);
  localparam logic [POS_W-1:0]  LAST_WIDE = POS_W'(BUF_SAMPLES - 1);

  // Configuration registers.
  logic signed [23:0] hp_b0;
  logic signed [23:0] hp_b1;
  logic signed [23:0] hp_b2;
  logic signed [23:0] hp_a1;
  logic signed [23:0] hp_a2;
  logic [20:0]        lp_alpha;
  logic [10:0]        clip_margin;
  logic [31:0]        dither_seed;

  // Filter and run state.
  logic signed [47:0] hp_delay_one;
  logic signed [47:0] hp_delay_two;
  logic signed [47:0] hp_out;
  logic signed [39:0] lp_memory;
  logic [31:0]        rng_word;
  logic [11:0]        low_mark;
  logic [11:0]        high_mark;
  logic [31:0]        clip_counter;
  logic [31:0]        sample_counter;
  logic               active_half;
  logic [FILL_W-1:0]  fill_index;

  // Per-item registers.
  logic signed [15:0] x_word;
  logic               dith_a;
  logic               dith_b;
  logic               item_half;
  logic [9:0]         item_pos;
  logic               item_full;

  // Sequencer and datapath registers.
  aacc_pkg::state_t   state;
  aacc_pkg::state_t   state_next;
  aacc_pkg::op_t      op;
  logic [1:0]         chunk;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_next;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sum_next;

  logic accept;
  logic mul_step;
  logic acc_step;
  logic load_out;

  aacc_pkg::op_ctrl_t ctrl;
  aacc_pkg::op_ctrl_t ctrl_succ;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hp_b0       <= aacc_pkg::HP_B0_RESET;
      hp_b1       <= aacc_pkg::HP_B1_RESET;
      hp_b2       <= aacc_pkg::HP_B2_RESET;
      hp_a1       <= aacc_pkg::HP_A1_RESET;
      hp_a2       <= aacc_pkg::HP_A2_RESET;
      lp_alpha    <= aacc_pkg::LP_ALPHA_RESET;
      clip_margin <= aacc_pkg::CLIP_MARGIN_RESET;
      dither_seed <= aacc_pkg::SEED_RESET;
    end else if (cfg_write) begin
      unique case (aacc_pkg::cfg_reg_t'(cfg_index))
        aacc_pkg::REG_HP_B0:       hp_b0       <= cfg_data[23:0];
        aacc_pkg::REG_HP_B1:       hp_b1       <= cfg_data[23:0];
        aacc_pkg::REG_HP_B2:       hp_b2       <= cfg_data[23:0];
        aacc_pkg::REG_HP_A1:       hp_a1       <= cfg_data[23:0];
        aacc_pkg::REG_HP_A2:       hp_a2       <= cfg_data[23:0];
        aacc_pkg::REG_LP_ALPHA:    lp_alpha    <= cfg_data[20:0];
        aacc_pkg::REG_CLIP_MARGIN: clip_margin <= cfg_data[10:0];
        aacc_pkg::REG_DITHER_SEED: dither_seed <= cfg_data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      aacc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = command ? aacc_pkg::ST_DONE : aacc_pkg::ST_MUL;
        end
      end
      aacc_pkg::ST_MUL: begin
        if (chunk == 2'd0) begin
          state_next = aacc_pkg::ST_ACC;
        end
      end
      aacc_pkg::ST_ACC: begin
        state_next = (op == aacc_pkg::OP_LP) ? aacc_pkg::ST_DONE : aacc_pkg::ST_MUL;
      end
      aacc_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = aacc_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_ready = (state == aacc_pkg::ST_IDLE);
    mul_step = (state == aacc_pkg::ST_MUL);
    acc_step = (state == aacc_pkg::ST_ACC);
    load_out = (state == aacc_pkg::ST_DONE) && (!out_valid || out_ready);
  end

  assign accept    = in_valid && in_ready;
  assign ctrl      = aacc_pkg::op_ctrl(op);
  assign ctrl_succ = aacc_pkg::op_ctrl(aacc_pkg::op_succ(op));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aacc_pkg::ST_IDLE;
      op    <= aacc_pkg::OP_Y;
      chunk <= 2'd0;
    end else begin
      state <= state_next;
      if (accept) begin
        op    <= aacc_pkg::OP_Y;
        chunk <= 2'd0;
      end else if (mul_step) begin
        chunk <= chunk - 2'd1;
      end else if (acc_step) begin
        op    <= aacc_pkg::op_succ(op);
        chunk <= (ctrl_succ.data == aacc_pkg::D_X) ? 2'd0 : 2'd2;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiply-accumulate unit
  // --------------------------------------------------------------------------
  logic [CW-1:0]        alpha_ext;
  logic [CW-1:0]        alpha_eff;
  logic [CW-1:0]        beta;
  logic signed [CW-1:0] mcand;
  logic signed [63:0]   y_scaled;
  logic signed [39:0]   u_val;
  logic signed [47:0]   dword;
  logic signed [16:0]   mdata;
  logic signed [CW+16:0] mult;
  logic                 first_chunk;

  assign alpha_ext = CW'(lp_alpha);
  assign alpha_eff = (alpha_ext > ONE_Q) ? ONE_Q : alpha_ext;
  assign beta      = ONE_Q - alpha_eff;

  always_comb begin
    unique case (ctrl.coef)
      aacc_pkg::C_B0:    mcand = CW'(hp_b0);
      aacc_pkg::C_B1:    mcand = CW'(hp_b1);
      aacc_pkg::C_B2:    mcand = CW'(hp_b2);
      aacc_pkg::C_A1:    mcand = CW'(hp_a1);
      aacc_pkg::C_A2:    mcand = CW'(hp_a2);
      aacc_pkg::C_ALPHA: mcand = $signed(alpha_eff);
      aacc_pkg::C_BETA:  mcand = $signed(beta);
      default:           mcand = '0;
    endcase
  end

  // The high-pass output moves from the coefficient fraction to 16 fraction
  // bits with a floor, then saturates to 40 bits.
  assign y_scaled = $signed({hp_out, 16'h0000}) >>> COEF_FRAC_BITS;
  always_comb begin
    if ((&y_scaled[63:39]) || !(|y_scaled[63:39])) begin
      u_val = y_scaled[39:0];
    end else begin
      u_val = y_scaled[63] ? {1'b1, 39'h0} : {1'b0, {39{1'b1}}};
    end
  end

  always_comb begin
    unique case (ctrl.data)
      aacc_pkg::D_Y:  dword = hp_out;
      aacc_pkg::D_U:  dword = 48'(u_val);
      aacc_pkg::D_LP: dword = 48'(lp_memory);
      default:        dword = 48'(x_word);
    endcase
  end

  // Wide operands are fed most significant slice first; only the top slice
  // carries the sign.
  always_comb begin
    if (ctrl.data == aacc_pkg::D_X) begin
      mdata = 17'(x_word);
    end else begin
      unique case (chunk)
        2'd2:    mdata = {dword[47], dword[47:32]};
        2'd1:    mdata = {1'b0, dword[31:16]};
        2'd0:    mdata = {1'b0, dword[15:0]};
        default: mdata = '0;
      endcase
    end
  end

  assign mult        = mcand * mdata;
  assign first_chunk = (ctrl.data == aacc_pkg::D_X) || (chunk == 2'd2);
  assign prod_next   = first_chunk ? PW'(mult) : (prod <<< 16) + PW'(mult);

  always_ff @(posedge clk) begin
    if (mul_step) begin
      prod <= prod_next;
    end
  end

  // Accumulate: each shifted product is floored on its own before it joins the sum.
  logic signed [PW-1:0] term_full;
  logic signed [SW-1:0] term;
  logic signed [SW-1:0] base;
  logic signed [SW-1:0] acc_in;
  logic signed [47:0]   sat48_v;
  logic signed [39:0]   sat40_v;

  assign term_full = ctrl.shift ? (prod >>> COEF_FRAC_BITS) : prod;
  assign term      = $signed(term_full[SW-1:0]);

  always_comb begin
    unique case (ctrl.base)
      aacc_pkg::B_D1: base = SW'(hp_delay_one);
      aacc_pkg::B_D2: base = SW'(hp_delay_two);
      default:        base = '0;
    endcase
  end

  assign acc_in   = ctrl.start ? base : sum;
  assign sum_next = ctrl.sub ? acc_in - term : acc_in + term;

  always_comb begin
    if ((&sum_next[SW-1:47]) || !(|sum_next[SW-1:47])) begin
      sat48_v = sum_next[47:0];
    end else begin
      sat48_v = sum_next[SW-1] ? {1'b1, 47'h0} : {1'b0, {47{1'b1}}};
    end
    if ((&sum_next[SW-1:39]) || !(|sum_next[SW-1:39])) begin
      sat40_v = sum_next[39:0];
    end else begin
      sat40_v = sum_next[SW-1] ? {1'b1, 39'h0} : {1'b0, {39{1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (acc_step) begin
      sum <= sum_next;
      if (ctrl.dest == aacc_pkg::W_Y) begin
        hp_out <= sat48_v;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run state, statistics and dither generator
  // --------------------------------------------------------------------------
  logic [31:0]       rng_step;
  logic              is_clip;
  logic [POS_W-1:0]  pos_wide;

  assign rng_step = rng_word * aacc_pkg::LCG_MUL + aacc_pkg::LCG_ADD;
  assign is_clip  = (raw_sample <= {1'b0, clip_margin})
                 || (raw_sample >= aacc_pkg::RAIL_MAX - {1'b0, clip_margin});
  assign pos_wide = POS_W'(fill_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      hp_delay_one   <= '0;
      hp_delay_two   <= '0;
      lp_memory      <= '0;
      rng_word       <= aacc_pkg::SEED_RESET;
      low_mark       <= aacc_pkg::RAIL_MAX;
      high_mark      <= '0;
      clip_counter   <= '0;
      sample_counter <= '0;
      active_half    <= 1'b0;
      fill_index     <= '0;
    end else if (accept && command) begin
      hp_delay_one   <= '0;
      hp_delay_two   <= '0;
      lp_memory      <= '0;
      rng_word       <= dither_seed;
      low_mark       <= aacc_pkg::RAIL_MAX;
      high_mark      <= '0;
      clip_counter   <= '0;
      sample_counter <= '0;
      active_half    <= 1'b0;
      fill_index     <= '0;
    end else if (accept) begin
      if (raw_sample < low_mark) begin
        low_mark <= raw_sample;
      end
      if (raw_sample > high_mark) begin
        high_mark <= raw_sample;
      end
      clip_counter   <= clip_counter + 32'(is_clip);
      sample_counter <= sample_counter + 32'd1;
      if (fill_index == LAST_FILL) begin
        fill_index  <= '0;
        active_half <= ~active_half;
      end else begin
        fill_index <= fill_index + 1'b1;
      end
    end else begin
      // The two dither draws happen in the multiply and accumulate steps of the first micro-op.
      if ((mul_step || acc_step) && (op == aacc_pkg::OP_Y)) begin
        rng_word <= rng_step;
      end
      if (acc_step && (ctrl.dest == aacc_pkg::W_D1)) begin
        hp_delay_one <= sat48_v;
      end
      if (acc_step && (ctrl.dest == aacc_pkg::W_D2)) begin
        hp_delay_two <= sat48_v;
      end
      if (acc_step && (ctrl.dest == aacc_pkg::W_LP)) begin
        lp_memory <= sat40_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_word    <= {~raw_sample[11], raw_sample[10:0], 4'h0};
      item_half <= command ? 1'b0 : active_half;
      item_pos  <= command ? 10'd0 : pos_wide[9:0];
      item_full <= !command && (fill_index == LAST_FILL);
    end
    if (accept && command) begin
      dith_a <= 1'b0;
      dith_b <= 1'b0;
    end else if (mul_step && (op == aacc_pkg::OP_Y)) begin
      dith_a <= rng_step[31];
    end else if (acc_step && (op == aacc_pkg::OP_Y)) begin
      dith_b <= rng_step[31];
    end
  end

  // --------------------------------------------------------------------------
  // Dither, truncation toward zero and output register
  // --------------------------------------------------------------------------
  logic signed [40:0] dith_val;
  logic signed [40:0] dith_sum;
  logic signed [40:0] trunc_in;
  logic signed [15:0] pcm_sat;

  always_comb begin
    if (dith_a && !dith_b) begin
      dith_val = 41'sd65536;
    end else if (!dith_a && dith_b) begin
      dith_val = -41'sd65536;
    end else begin
      dith_val = '0;
    end
  end

  assign dith_sum = 41'(lp_memory) + dith_val;
  // Adding 2^16 - 1 to negative values turns the floor shift into truncation.
  assign trunc_in = dith_sum + (dith_sum[40] ? 41'sd65535 : 41'sd0);

  always_comb begin
    if ((&trunc_in[40:31]) || !(|trunc_in[40:31])) begin
      pcm_sat = trunc_in[31:16];
    end else begin
      pcm_sat = trunc_in[40] ? 16'sh8000 : 16'sh7FFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pcm_out        <= pcm_sat;
      buffer_select  <= item_half;
      write_position <= item_pos;
      buffer_full    <= item_full;
      min_raw        <= low_mark;
      max_raw        <= high_mark;
      clip_total     <= clip_counter;
      sample_total   <= sample_counter;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sample_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (accept && !command) |=> !in_ready)
    else $error("input taken while a sample item is in progress");

  a_marks_ordered: assert property (@(posedge clk) disable iff (rst)
    (sample_counter != 32'd0) |-> (low_mark <= high_mark))
    else $error("raw minimum above raw maximum after samples");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill_index <= LAST_FILL)
    else $error("buffer slot index past the last slot");

  a_full_at_last_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && buffer_full) |-> (write_position == LAST_WIDE[9:0]))
    else $error("buffer full flagged away from the last slot");

  a_done_holds_result: assert property (@(posedge clk) disable iff (rst)
    (state == aacc_pkg::ST_DONE && out_valid && !out_ready) |=>
      (state == aacc_pkg::ST_DONE))
    else $error("sequencer left done while the previous result was pending");

endmodule

`default_nettype wire

// ----- test/tb_adc_audio_conditioning_chain_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the ADC audio conditioning chain
// Drives sample and restart items through valid/ready with random gaps and
// output stalls, rewrites the coefficient, alpha, margin and seed registers
// between phases, and checks every result field against a cycle-free model
// of the statistics, biquad, low-pass, dither and buffer bookkeeping.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_adc_audio_conditioning_chain_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import aacc_pkg::*;

  localparam int     FRAC        = 20;
  localparam int     BUF_SLOTS   = 1024;
  localparam longint UNITY       = longint'(1) << FRAC;
  localparam bit     CMD_SAMPLE  = 1'b0;
  localparam bit     CMD_RESTART = 1'b1;
  localparam int     N_DIRECTED  = 22;
  localparam int     N_PHASES    = 8;
  localparam int     PHASE_ITEMS = 200;
  localparam int     MAX_REPORTS = 200;

  typedef struct packed {
    logic signed [15:0] pcm;
    logic               half;
    logic [9:0]         slot;
    logic               full;
    logic [11:0]        lo_raw;
    logic [11:0]        hi_raw;
    logic [31:0]        clips;
    logic [31:0]        total;
  } chain_result_t;

  typedef struct packed {
    bit            cmd;
    logic [11:0]   raw;
    bit            typed;
    chain_result_t want;
  } directed_row_t;

  localparam chain_result_t RESTART_RESULT = '{pcm: 16'sd0, half: 1'b0, slot: 10'd0,
    full: 1'b0, lo_raw: RAIL_MAX, hi_raw: 12'd0, clips: 32'd0, total: 32'd0};

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = 3'd0;
  logic [31:0]        cfg_data = 32'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               command = 1'b0;
  logic [11:0]        raw_sample = 12'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] pcm_out;
  logic               buffer_select;
  logic [9:0]         write_position;
  logic               buffer_full;
  logic [11:0]        min_raw;
  logic [11:0]        max_raw;
  logic [31:0]        clip_total;
  logic [31:0]        sample_total;

  // Register mirror.
  longint      coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic [20:0] alpha_now;
  logic [10:0] margin_now;
  logic [31:0] seed_now;

  // Chain state mirror.
  longint      hp_z1, hp_z2, lp_z;
  logic [31:0] rng_now;
  logic [11:0] low_now, high_now;
  logic [31:0] clip_now, count_now;
  logic        half_now;
  int          slot_now;

  chain_result_t chain_results_due[$];
  logic [31:0]   next_regs [8];
  int            mismatches = 0;
  int            results_seen = 0;
  bit            src_quiet = 1'b0;
  bit            sink_quiet = 1'b0;

  adc_audio_conditioning_chain_unit dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .raw_sample     (raw_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pcm_out        (pcm_out),
    .buffer_select  (buffer_select),
    .write_position (write_position),
    .buffer_full    (buffer_full),
    .min_raw        (min_raw),
    .max_raw        (max_raw),
    .clip_total     (clip_total),
    .sample_total   (sample_total)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint clamp_bits(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Coefficient product taken down by FRAC, with the whole and fractional
  // parts of v floored separately.
  function automatic longint frac_mul(longint c, longint v);
    longint hi, lo;
    hi = v >>> FRAC;
    lo = v - (hi <<< FRAC);
    return c * hi + ((c * lo) >>> FRAC);
  endfunction

  function automatic void clear_run();
    hp_z1 = 0;
    hp_z2 = 0;
    lp_z = 0;
    low_now = RAIL_MAX;
    high_now = 12'd0;
    clip_now = 32'd0;
    count_now = 32'd0;
    half_now = 1'b0;
    slot_now = 0;
  endfunction

  function automatic void mirror_reset();
    coef_b0 = longint'(HP_B0_RESET);
    coef_b1 = longint'(HP_B1_RESET);
    coef_b2 = longint'(HP_B2_RESET);
    coef_a1 = longint'(HP_A1_RESET);
    coef_a2 = longint'(HP_A2_RESET);
    alpha_now = LP_ALPHA_RESET;
    margin_now = CLIP_MARGIN_RESET;
    seed_now = SEED_RESET;
    clear_run();
    rng_now = SEED_RESET;
  endfunction

  function automatic void mirror_reg(cfg_reg_t idx, logic [31:0] d);
    case (idx)
      REG_HP_B0:       coef_b0 = longint'($signed(d[23:0]));
      REG_HP_B1:       coef_b1 = longint'($signed(d[23:0]));
      REG_HP_B2:       coef_b2 = longint'($signed(d[23:0]));
      REG_HP_A1:       coef_a1 = longint'($signed(d[23:0]));
      REG_HP_A2:       coef_a2 = longint'($signed(d[23:0]));
      REG_LP_ALPHA:    alpha_now = d[20:0];
      REG_CLIP_MARGIN: margin_now = d[10:0];
      REG_DITHER_SEED: seed_now = d;
      default: ;
    endcase
  endfunction

  function automatic chain_result_t chain_step(bit cmd, logic [11:0] raw);
    chain_result_t r;
    longint x, y, u, a, v, t;
    bit dith_a, dith_b;
    r = RESTART_RESULT;
    if (cmd == CMD_RESTART) begin
      clear_run();
      rng_now = seed_now;
      return r;
    end
    if (raw < low_now) low_now = raw;
    if (raw > high_now) high_now = raw;
    if (int'(raw) <= int'(margin_now) || int'(raw) >= int'(RAIL_MAX) - int'(margin_now))
      clip_now = clip_now + 1;

    x = (longint'(raw) - 2048) * 16;
    y = clamp_bits(coef_b0 * x + hp_z1, 48);
    hp_z1 = clamp_bits(coef_b1 * x - frac_mul(coef_a1, y) + hp_z2, 48);
    hp_z2 = clamp_bits(coef_b2 * x - frac_mul(coef_a2, y), 48);
    u = clamp_bits(y >>> (FRAC - LP_FRAC), 40);

    a = (longint'(alpha_now) > UNITY) ? UNITY : longint'(alpha_now);
    lp_z = clamp_bits(frac_mul(a, u) + frac_mul(UNITY - a, lp_z), 40);

    rng_now = rng_now * LCG_MUL + LCG_ADD;
    dith_a = rng_now[31];
    rng_now = rng_now * LCG_MUL + LCG_ADD;
    dith_b = rng_now[31];
    v = lp_z + (longint'(dith_a) - longint'(dith_b)) * (longint'(1) << LP_FRAC);
    t = (v >= 0) ? (v >>> LP_FRAC) : -((-v) >>> LP_FRAC);
    t = clamp_bits(t, 16);

    r.pcm = t[15:0];
    r.half = half_now;
    r.slot = slot_now[9:0];
    count_now = count_now + 1;
    slot_now = slot_now + 1;
    r.full = 1'b0;
    if (slot_now >= BUF_SLOTS) begin
      r.full = 1'b1;
      half_now = ~half_now;
      slot_now = 0;
    end
    r.lo_raw = low_now;
    r.hi_raw = high_now;
    r.clips = clip_now;
    r.total = count_now;
    return r;
  endfunction

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 16));
  endfunction

  // Mostly full-scale values, with extra weight near the rails and mid-scale.
  function automatic logic [11:0] draw_raw();
    int r;
    case ($urandom_range(0, 3))
      0, 1: return 12'($urandom_range(0, 4095));
      2: begin
        r = $urandom_range(0, 15);
        return $urandom_range(0, 1) ? 12'(r) : 12'(4095 - r);
      end
      default: return 12'(2048 - 64 + $urandom_range(0, 128));
    endcase
  endfunction

  task automatic report_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("result %0d: %s", results_seen, msg);
  endtask

  function automatic void set_default_regs();
    next_regs[REG_HP_B0] = 32'(HP_B0_RESET);
    next_regs[REG_HP_B1] = 32'(HP_B1_RESET);
    next_regs[REG_HP_B2] = 32'(HP_B2_RESET);
    next_regs[REG_HP_A1] = 32'(HP_A1_RESET);
    next_regs[REG_HP_A2] = 32'(HP_A2_RESET);
    next_regs[REG_LP_ALPHA] = 32'(LP_ALPHA_RESET);
    next_regs[REG_CLIP_MARGIN] = 32'(CLIP_MARGIN_RESET);
    next_regs[REG_DITHER_SEED] = $urandom();
  endfunction

  task automatic pick_settings(int p);
    int i;
    case (p)
      0: set_default_regs();
      1: begin
        // Top of every range; alpha beyond one must clamp, margin covers all.
        for (i = REG_HP_B0; i <= REG_HP_A2; i++) next_regs[i] = 32'hFF7F_FFFF;
        next_regs[REG_LP_ALPHA] = 32'h001F_FFFF;
        next_regs[REG_CLIP_MARGIN] = 32'h0000_07FF;
        next_regs[REG_DITHER_SEED] = 32'hFFFF_FFFF;
      end
      2: begin
        for (i = REG_HP_B0; i <= REG_HP_A2; i++) next_regs[i] = 32'h0080_0000;
        next_regs[REG_LP_ALPHA] = 32'd0;
        next_regs[REG_CLIP_MARGIN] = 32'd0;
        next_regs[REG_DITHER_SEED] = 32'd0;
      end
      4: begin
        set_default_regs();
        next_regs[REG_LP_ALPHA] = 32'(UNITY);
        next_regs[REG_CLIP_MARGIN] = $urandom_range(0, 2047);
      end
      5: begin
        set_default_regs();
        next_regs[REG_LP_ALPHA] = $urandom_range(0, 1 << FRAC);
        next_regs[REG_CLIP_MARGIN] = $urandom_range(0, 64);
      end
      7: begin
        for (i = REG_HP_B0; i <= REG_HP_A2; i++)
          next_regs[i] = int'($urandom_range(0, 1 << (FRAC + 1))) - (1 << FRAC);
        next_regs[REG_LP_ALPHA] = $urandom_range(0, (1 << (FRAC + 1)) - 1);
        next_regs[REG_CLIP_MARGIN] = $urandom_range(0, 2047);
        next_regs[REG_DITHER_SEED] = 32'hFFFF_FFFF;
      end
      default: begin
        for (i = 0; i < 8; i++) next_regs[i] = $urandom();
        if (p == 6) next_regs[REG_DITHER_SEED] = 32'd0;
      end
    endcase
  endtask

  // Called on a clock edge with the block idle; one register per cycle.
  task automatic load_settings();
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= next_regs[i];
      @(posedge clk);
      mirror_reg(cfg_reg_t'(i), next_regs[i]);
    end
    cfg_write <= 1'b0;
  endtask

  // Called on a clock edge. Valid is left high when the next item follows
  // at once; the caller lowers it when no item follows.
  task automatic push_item(bit cmd, logic [11:0] raw, bit typed, chain_result_t want,
                           bit quiet);
    chain_result_t predicted;
    bit taken;
    int gap;
    in_valid <= 1'b1;
    command <= cmd;
    raw_sample <= raw;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    predicted = chain_step(cmd, raw);
    chain_results_due.push_back(typed ? want : predicted);
    gap = draw_wait(quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_result(chain_result_t seen);
    chain_result_t due;
    results_seen++;
    if (chain_results_due.size() == 0) begin
      report_error("result arrived with nothing pending");
      return;
    end
    due = chain_results_due.pop_front();
    if (seen.pcm !== due.pcm)
      report_error($sformatf("pcm_out %0d, expected %0d", seen.pcm, due.pcm));
    if (seen.half !== due.half)
      report_error($sformatf("buffer_select %0d, expected %0d", seen.half, due.half));
    if (seen.slot !== due.slot)
      report_error($sformatf("write_position %0d, expected %0d", seen.slot, due.slot));
    if (seen.full !== due.full)
      report_error($sformatf("buffer_full %0d, expected %0d", seen.full, due.full));
    if (seen.lo_raw !== due.lo_raw)
      report_error($sformatf("min_raw %0d, expected %0d", seen.lo_raw, due.lo_raw));
    if (seen.hi_raw !== due.hi_raw)
      report_error($sformatf("max_raw %0d, expected %0d", seen.hi_raw, due.hi_raw));
    if (seen.clips !== due.clips)
      report_error($sformatf("clip_total %0d, expected %0d", seen.clips, due.clips));
    if (seen.total !== due.total)
      report_error($sformatf("sample_total %0d, expected %0d", seen.total, due.total));
  endtask

  initial begin : result_sink
    chain_result_t seen;
    bit took;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait(sink_quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      took = 1'b0;
      while (!took) begin
        @(negedge clk);
        took = out_valid;
        seen = '{pcm_out, buffer_select, write_position, buffer_full, min_raw, max_raw,
                 clip_total, sample_total};
        @(posedge clk);
      end
      check_result(seen);
    end
  end

  initial begin : stimulus
    directed_row_t directed_rows [N_DIRECTED];
    int p, n;
    bit cmd;
    mirror_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Runs on the reset register values. A restart ignores its sample bits.
    directed_rows = '{
      '{CMD_RESTART, 12'h000, 1'b1, RESTART_RESULT},
      '{CMD_RESTART, 12'hFFF, 1'b1, RESTART_RESULT},
      '{CMD_SAMPLE,  12'd0,    1'b0, '0},
      '{CMD_SAMPLE,  12'd4095, 1'b0, '0},
      '{CMD_SAMPLE,  12'd2048, 1'b0, '0},
      '{CMD_SAMPLE,  12'd2047, 1'b0, '0},
      '{CMD_SAMPLE,  12'd4,    1'b0, '0},
      '{CMD_SAMPLE,  12'd5,    1'b0, '0},
      '{CMD_SAMPLE,  12'd4090, 1'b0, '0},
      '{CMD_SAMPLE,  12'd4091, 1'b0, '0},
      '{CMD_SAMPLE,  12'd3,    1'b0, '0},
      '{CMD_SAMPLE,  12'd4092, 1'b0, '0},
      '{CMD_SAMPLE,  12'd2049, 1'b0, '0},
      '{CMD_SAMPLE,  12'hAAA,  1'b0, '0},
      '{CMD_SAMPLE,  12'h555,  1'b0, '0},
      '{CMD_RESTART, 12'hFFF, 1'b1, RESTART_RESULT},
      '{CMD_SAMPLE,  12'd2048, 1'b0, '0},
      '{CMD_SAMPLE,  12'd0,    1'b0, '0},
      '{CMD_SAMPLE,  12'd4095, 1'b0, '0},
      '{CMD_SAMPLE,  12'd1,    1'b0, '0},
      '{CMD_SAMPLE,  12'd4094, 1'b0, '0},
      '{CMD_SAMPLE,  12'd0,    1'b0, '0}
    };
    for (n = 0; n < N_DIRECTED; n++)
      push_item(directed_rows[n].cmd, directed_rows[n].raw, directed_rows[n].typed,
                directed_rows[n].want, 1'b0);

    // Phases one through five carry no restart, so the sample count runs past
    // a full buffer half and the half toggles.
    for (p = 0; p < N_PHASES; p++) begin
      in_valid <= 1'b0;
      while (chain_results_due.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      pick_settings(p);
      load_settings();
      src_quiet = (p == 2 || p == 5);
      sink_quiet = (p == 2 || p == 6);
      if (p == 0 || p >= 6)
        push_item(CMD_RESTART, draw_raw(), 1'b0, '0, src_quiet);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        cmd = (p >= 6 && $urandom_range(0, 15) == 0) ? CMD_RESTART : CMD_SAMPLE;
        push_item(cmd, draw_raw(), 1'b0, '0, src_quiet);
      end
    end
    in_valid <= 1'b0;

    while (chain_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (chain_results_due.size() != 0)
      report_error("results still pending at the end");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
